[sv/ddf_pkg.sv]
// Shared types and constants for the decimal digit formatter.
package ddf_pkg;

   localparam int VALUE_W     = 32;
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] CODE_SPACE = 6'd32;
   localparam logic [5:0] CODE_ZERO  = 6'd48;

   typedef struct packed {
      logic [9:0]         start_column;
      logic [9:0]         row;
      logic [VALUE_W-1:0] value;
      logic [3:0]         count;
      logic [5:0]         font_size;
   } item_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT
   } back_state_type;

endpackage

[sv/decimal_digit_formatter.sv]
// Top level of the decimal digit formatter: front end, queue and back end.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall start_column row value digit_count font_size
//   rsp      out        rsp_valid/rsp_stall char_code column out_row out_size last
//
// The back end loads a request, runs serial BCD conversion (one value bit per cycle)
// and then emits digit_count characters.
// The front end and a two-entry queue keep taking requests while the back end works.
// Synchronous active-high reset empties the queue and drops any run in progress.
// A stalled response holds; the back end waits until the output register is free.
module decimal_digit_formatter #(
   parameter int MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_start_column,
   input  logic [9:0]  req_row,
   input  logic [31:0] req_value,
   input  logic [3:0]  req_digit_count,
   input  logic [5:0]  req_font_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_char_code,
   output logic [10:0] rsp_column,
   output logic [9:0]  rsp_out_row,
   output logic [5:0]  rsp_out_size,
   output logic        rsp_last
);
   import ddf_pkg::*;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   ddf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_column (req_start_column),
      .req_row          (req_row),
      .req_value        (req_value),
      .req_digit_count  (req_digit_count),
      .req_font_size    (req_font_size),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   ddf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ddf_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_column    (rsp_column),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_size  (rsp_out_size),
      .rsp_last      (rsp_last)
   );

endmodule

[sv/ddf_front.sv]
// Front end: accepts requests, clamps the digit count and drops empty runs.
module ddf_front #(
   parameter int MAX_DIGITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [9:0]        req_start_column,
   input  logic [9:0]        req_row,
   input  logic [31:0]       req_value,
   input  logic [3:0]        req_digit_count,
   input  logic [5:0]        req_font_size,
   output logic              push_valid,
   input  logic              push_ready,
   output ddf_pkg::item_type push_item
);
   import ddf_pkg::*;

   logic     front_valid_ff, front_valid_in;
   item_type front_item_ff, front_item_in;
   logic     accept;
   logic     push;
   logic [3:0] count_clamped;

   assign push       = front_valid_ff && push_ready;
   assign req_stall  = front_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

   always_comb begin
      count_clamped = (req_digit_count > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : req_digit_count;
      front_item_in = front_item_ff;
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_item_in.start_column = req_start_column;
         front_item_in.row          = req_row;
         front_item_in.value        = req_value;
         front_item_in.count        = count_clamped;
         front_item_in.font_size    = req_font_size;
         // a zero count produces no characters: drop it here
         front_valid_in = (count_clamped != 4'd0);
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

endmodule

[sv/ddf_queue.sv]
// Short queue of classified items between the front and back ends.
module ddf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ddf_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ddf_pkg::item_type pop_item
);
   import ddf_pkg::*;

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 push;
   logic                 pop;

   assign push_ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

[sv/ddf_back.sv]
// Back end: serial binary to BCD conversion, then one character per cycle while the output is not stalled.
module ddf_back #(
   parameter int MAX_DIGITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ddf_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [5:0]        rsp_char_code,
   output logic [10:0]       rsp_column,
   output logic [9:0]        rsp_out_row,
   output logic [5:0]        rsp_out_size,
   output logic              rsp_last
);
   import ddf_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   back_state_type       state_ff, state_in;
   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic [3:0]           digit_ff [MAX_DIGITS];
   logic [3:0]           digit_in [MAX_DIGITS];
   logic [3:0]           adj      [MAX_DIGITS];
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [3:0]           count_ff, count_in;
   logic [10:0]          col_ff, col_in;
   logic [4:0]           half_ff, half_in;
   logic [9:0]           row_ff, row_in;
   logic [5:0]           size_ff, size_in;
   logic                 shown_ff, shown_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           rsp_code_ff, rsp_code_in;
   logic [10:0]          rsp_col_ff, rsp_col_in;
   logic [9:0]           rsp_row_ff, rsp_row_in;
   logic [5:0]           rsp_size_ff, rsp_size_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 pop;
   logic                 emit_fire;
   logic                 convert_done;
   logic [3:0]           cur_digit;
   logic                 blank;

   assign cur_digit    = digit_ff[idx_ff];
   assign blank        = !shown_ff && (idx_ff != '0) && (cur_digit == 4'd0);
   assign convert_done = (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1));

   // control outputs
   always_comb begin
      pop_ready = (state_ff == BACK_IDLE);
      pop       = pop_valid && pop_ready;
      emit_fire = (state_ff == BACK_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE:    if (pop_valid) state_in = BACK_CONVERT;
         BACK_CONVERT: if (convert_done) state_in = BACK_EMIT;
         BACK_EMIT:    if (emit_fire && idx_ff == '0) state_in = BACK_IDLE;
         default:      state_in = BACK_IDLE;
      endcase
   end

   // add-3 correction on every digit ahead of the shift
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         adj[k] = (digit_ff[k] >= 4'd5) ? digit_ff[k] + 4'd3 : digit_ff[k];
      end
   end

   // datapath
   always_comb begin
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      col_in     = col_ff;
      half_in    = half_ff;
      row_in     = row_ff;
      size_in    = size_ff;
      shown_in   = shown_ff;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         digit_in[k] = digit_ff[k];
      end
      rsp_code_in = rsp_code_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_size_in = rsp_size_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;

      if (pop) begin
         shift_in   = pop_item.value;
         bit_cnt_in = '0;
         count_in   = pop_item.count;
         col_in     = {1'b0, pop_item.start_column};
         half_in    = pop_item.font_size[5:1];
         row_in     = pop_item.row;
         size_in    = pop_item.font_size;
         shown_in   = 1'b0;
         for (int k = 0; k < MAX_DIGITS; k++) begin
            digit_in[k] = 4'd0;
         end
      end

      if (state_ff == BACK_CONVERT) begin
         // carry out of the top digit is dropped: keeps value mod 10^MAX_DIGITS
         digit_in[0] = {adj[0][2:0], shift_ff[VALUE_W-1]};
         for (int k = 1; k < MAX_DIGITS; k++) begin
            digit_in[k] = {adj[k][2:0], adj[k-1][3]};
         end
         shift_in   = {shift_ff[VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         idx_in     = IDX_W'(count_ff - 4'd1);
      end

      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = blank ? CODE_SPACE : CODE_ZERO + {2'b00, cur_digit};
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_size_in  = size_ff;
         rsp_last_in  = (idx_ff == '0);
         shown_in     = shown_ff || !blank;
         col_in       = col_ff + {6'b000000, half_ff};
         idx_in       = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff   <= shift_in;
      bit_cnt_ff <= bit_cnt_in;
      idx_ff     <= idx_in;
      count_ff   <= count_in;
      col_ff     <= col_in;
      half_ff    <= half_in;
      row_ff     <= row_in;
      size_ff    <= size_in;
      shown_ff   <= shown_in;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         digit_ff[k] <= digit_in[k];
      end
      rsp_code_ff <= rsp_code_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_size_ff <= rsp_size_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_code_ff;
   assign rsp_column    = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_size  = rsp_size_ff;
   assign rsp_last      = rsp_last_ff;

   a_last_not_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_code_ff != CODE_SPACE))
      else $error("final character was blanked");

   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT) |-> (cur_digit <= 4'd9))
      else $error("converted digit out of range");

   a_full_convert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_CONVERT && !convert_done) |=> (state_ff == BACK_CONVERT))
      else $error("conversion left early");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the decimal digit formatter: directed, random and hold-off tests.
module tb_top;
   import ddf_pkg::*;

   localparam int MAX_DIGITS      = 10;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int RANDOM_ITEMS    = 185;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [5:0]  char_code;
      logic [10:0] column;
      logic [9:0]  out_row;
      logic [5:0]  out_size;
      logic        last;
   } char_slot_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [9:0]  req_start_column;
   logic [9:0]  req_row;
   logic [31:0] req_value;
   logic [3:0]  req_digit_count;
   logic [5:0]  req_font_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_char_code;
   logic [10:0] rsp_column;
   logic [9:0]  rsp_out_row;
   logic [5:0]  rsp_out_size;
   logic        rsp_last;

   char_slot_type pending_chars[$];
   int            mismatches;
   int            requests_sent;
   int            chars_checked;
   int            blank_requests;
   int            cycle_count;
   int            hold_left;
   bit            req_idle_on;
   bit            rsp_idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   decimal_digit_formatter #(
      .MAX_DIGITS(MAX_DIGITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_column(req_start_column),
      .req_row         (req_row),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .req_font_size   (req_font_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_code   (rsp_char_code),
      .rsp_column      (rsp_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_size    (rsp_out_size),
      .rsp_last        (rsp_last)
   );

   // Queue the characters one request should produce, most significant first.
   function automatic void format_digits(item_type it);
      logic [31:0]   rest;
      logic [3:0]    digs [10];
      logic [3:0]    d;
      int            n;
      logic          shown;
      char_slot_type s;
      rest = it.value;
      for (int k = 0; k < 10; k++) begin
         digs[k] = 4'(rest % 10);
         rest    = rest / 10;
      end
      n     = (it.count > MAX_DIGITS) ? MAX_DIGITS : int'(it.count);
      shown = 1'b0;
      for (int t = 0; t < n; t++) begin
         d = digs[n - 1 - t];
         // blank leading zeros, but never the final position
         if (!shown && t < n - 1 && d == 4'd0) begin
            s.char_code = CODE_SPACE;
         end else begin
            shown       = 1'b1;
            s.char_code = CODE_ZERO + d;
         end
         s.column   = 11'(it.start_column + (it.font_size >> 1) * t);
         s.out_row  = it.row;
         s.out_size = it.font_size;
         s.last     = (t == n - 1);
         pending_chars.push_back(s);
      end
      if (n == 0) blank_requests++;
   endfunction

   function automatic item_type make_item(int col, int row, logic [31:0] value, int count,
                                          int size);
      item_type it;
      it.start_column = col[9:0];
      it.row          = row[9:0];
      it.value        = value;
      it.count        = count[3:0];
      it.font_size    = size[5:0];
      return it;
   endfunction

   // Value with a random number of decimal digits, sometimes with a zero punched in.
   function automatic logic [31:0] pick_value();
      logic [63:0] v;
      logic [63:0] scale;
      int          n;
      int          k;
      n     = $urandom_range(1, 10);
      v     = {$urandom, $urandom};
      scale = 64'd1;
      repeat (n) scale = scale * 10;
      v = v % scale;
      if (v[63:32] != 32'd0) v = {32'd0, $urandom};
      if ($urandom_range(0, 2) == 0) begin
         k     = $urandom_range(0, n - 1);
         scale = 64'd1;
         repeat (k) scale = scale * 10;
         v = v - ((v / scale) % 10) * scale;
      end
      if ($urandom_range(0, 9) == 0) v = {32'd0, $urandom};
      return v[31:0];
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 10) return $urandom_range(11, 15);
      return $urandom_range(1, 10);
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_item(item_type it);
      int gap;
      int r;
      gap = 0;
      if (req_idle_on) begin
         r = $urandom_range(0, 99);
         if (r < 60) gap = 0;
         else if (r < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 50);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_start_column <= it.start_column;
      req_row          <= it.row;
      req_value        <= it.value;
      req_digit_count  <= it.count;
      req_font_size    <= it.font_size;
      do @(posedge clock); while (req_stall);
      format_digits(it);
      requests_sent++;
   endtask

   task automatic test_extremes();
      send_item(make_item(0, 0, 32'd0, 10, 0));
      send_item(make_item(1023, 1023, 32'hFFFF_FFFF, 10, 63));
      send_item(make_item(1023, 0, 32'hFFFF_FFFF, 1, 62));
      send_item(make_item(512, 341, 32'h8000_0000, 10, 1));
      send_item(make_item(682, 682, 32'h5555_5555, 10, 42));
   endtask

   task automatic test_count_range();
      int counts [8] = '{0, 1, 2, 9, 10, 11, 15, 0};
      foreach (counts[i])
         send_item(make_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                             (i == 7) ? 32'd0 : 32'd1234567890, counts[i],
                             $urandom_range(0, 63)));
   endtask

   task automatic test_zero_blanking();
      send_item(make_item(10, 20, 32'd0, 1, 16));
      send_item(make_item(10, 20, 32'd0, 5, 16));
      send_item(make_item(100, 200, 32'd7, 10, 24));
      send_item(make_item(100, 200, 32'd1000200, 9, 24));
      send_item(make_item(300, 5, 32'd100000, 3, 33));
      send_item(make_item(300, 5, 32'hFFFF_FFFF, 4, 33));
      send_item(make_item(0, 1, 32'd120, 10, 8));
   endtask

   task automatic test_random_values();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // leave stretches where neither side idles
         req_idle_on = (i % 50) >= 12;
         rsp_idle_on = (i % 60) >= 15;
         send_item(make_item($urandom_range(0, 1023), $urandom_range(0, 1023), pick_value(),
                             pick_count(), $urandom_range(0, 63)));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Hold the output for a long stretch while requests keep coming back to back.
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_left   = HOLD_OFF_CYCLES;
      for (int i = 0; i < 8; i++)
         send_item(make_item($urandom_range(0, 1023), $urandom_range(0, 1023), pick_value(),
                             10, $urandom_range(0, 63)));
      req_idle_on = 1'b1;
   endtask

   // Output stall pattern: hold-off first, then random bursts.
   initial begin
      int burst_left;
      bit burst_val;
      int r;
      rsp_stall  = 1'b0;
      burst_left = 0;
      burst_val  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!rsp_idle_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 50) begin
                  burst_val  = 1'b0;
                  burst_left = $urandom_range(1, 8);
               end else if (r < 90) begin
                  burst_val  = 1'b1;
                  burst_left = $urandom_range(1, 3);
               end else begin
                  burst_val  = 1'b1;
                  burst_left = $urandom_range(10, 40);
               end
            end
            burst_left--;
            rsp_stall <= burst_val;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      char_slot_type got;
      char_slot_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_char_code, rsp_column, rsp_out_row, rsp_out_size, rsp_last};
         chars_checked++;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected transaction: code %0d col %0d row %0d size %0d last %0d",
                        got.char_code, got.column, got.out_row, got.out_size, got.last);
         end else begin
            want = pending_chars.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch code/col/row/size/last: exp %0d/%0d/%0d/%0d/%0d %s",
                           want.char_code, want.column, want.out_row, want.out_size,
                           want.last,
                           $sformatf("got %0d/%0d/%0d/%0d/%0d", got.char_code,
                                     got.column, got.out_row, got.out_size, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
                  pending_chars.size());
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_start_column = '0;
      req_row          = '0;
      req_value        = '0;
      req_digit_count  = '0;
      req_font_size    = '0;
      hold_left        = 0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      mismatches       = 0;
      requests_sent    = 0;
      chars_checked    = 0;
      blank_requests   = 0;
      cycle_count      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_count_range();
      test_zero_blanking();
      test_random_values();
      test_backpressure();

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d characters checked, %0d requests with no output",
               requests_sent, chars_checked, blank_requests);
      $display("summary: digit counts 0..15, zero blanking, field extremes, long output hold-off");
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[sim.f]
sv/ddf_pkg.sv
sv/ddf_front.sv
sv/ddf_queue.sv
sv/ddf_back.sv
sv/decimal_digit_formatter.sv
tb/tb_top.sv
